/* hdl/crse_pkg.sv */
// Shared types and codes for the Catmull-Rom spline evaluator.
`default_nettype none

package crse_pkg;

    // Item kinds carried on tuser
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_POS   = 2'd1;
    localparam logic [1:0] MODE_TAN   = 2'd2;
    localparam logic [1:0] MODE_ACC   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_EVAL    = 2'd0;
    localparam logic [1:0] ST_FEW     = 2'd1;
    localparam logic [1:0] ST_WRITTEN = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef logic signed [31:0] coord_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  status;
        logic [16:0] u;       // local parameter, Q1.16, 0..65536
        coord_t      x;
        coord_t      y;
        coord_t      z;
    } crse_item_t;

endpackage

`default_nettype wire

/* hdl/crse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module crse_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/crse_fifo.sv */
// Short queue between the front end and the back end.
`default_nettype none

module crse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/crse_front.sv */
// Front end: point count register, item classification, segment and local t.
`default_nettype none

module crse_front #(
    parameter int MAX_POINTS = 64,
    localparam int AW        = $clog2(MAX_POINTS),
    localparam int SW        = (AW > 7) ? AW : 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [6:0]           cfg_wr_data,
    input  logic [1:0]           mode,
    input  logic [5:0]           point_index,
    input  crse_pkg::coord_t     coord_x,
    input  crse_pkg::coord_t     coord_y,
    input  crse_pkg::coord_t     coord_z,
    input  logic [16:0]          param_t,
    output crse_pkg::crse_item_t item,
    output logic [SW-1:0]        slot
);

    import crse_pkg::*;

    logic [6:0]  count_reg, count_next;
    logic [6:0]  n_use, n_m3;
    logic [16:0] t_clamp;
    logic [23:0] s_prod, s_ceil, u_diff;
    logic [7:0]  p_seg, p_m1;

    assign count_next = cfg_wr_en ? cfg_wr_data : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        n_use   = (32'(count_reg) > 32'(MAX_POINTS)) ? 7'(MAX_POINTS) : count_reg;
        n_m3    = n_use - 7'd3;
        t_clamp = (param_t > 17'd65536) ? 17'd65536 : param_t;
        // s = (n-3)*t in Q.16, segment p = ceil(s), zero taken as one
        s_prod  = 24'(n_m3) * 24'(t_clamp);
        s_ceil  = s_prod + 24'd65535;
        p_seg   = s_ceil[23:16];
        if (p_seg == 8'd0) begin
            p_seg = 8'd1;
        end
        p_m1    = p_seg - 8'd1;
        u_diff  = s_prod - {p_m1, 16'd0};

        item.mode = mode;
        item.u    = u_diff[16:0];
        item.x    = coord_x;
        item.y    = coord_y;
        item.z    = coord_z;
        if (mode == MODE_WRITE) begin
            slot        = SW'(point_index);
            item.status = ({1'b0, point_index} < n_use) ? ST_WRITTEN : ST_IGNORED;
        end else begin
            slot        = SW'(p_m1);
            item.status = (n_use < 7'd4) ? ST_FEW : ST_EVAL;
        end
    end

endmodule

`default_nettype wire

/* hdl/crse_back.sv */
// Back end: point store, basis weights, multiply-accumulate, rounding, output register.
`default_nettype none

module crse_back #(
    parameter int MAX_POINTS = 64,
    localparam int AW        = $clog2(MAX_POINTS),
    localparam int SW        = (AW > 7) ? AW : 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  crse_pkg::crse_item_t in_item,
    input  logic [SW-1:0]        in_slot,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    import crse_pkg::*;

    logic adv, pop, ram_we, ram_re;

    logic [SW-1:0] rd_slot [4];
    logic [AW-1:0] rd_addr [4];
    logic [95:0]   rd_data [4];

    // stage 1: read issued, u^2
    logic        v1_reg;
    logic [1:0]  st1_reg, mode1_reg;
    logic [16:0] u1_reg;
    logic [32:0] usq1_reg;
    logic [33:0] usq_full;
    // stage 2: points, u^3
    logic        v2_reg;
    logic [1:0]  st2_reg, mode2_reg;
    logic [16:0] u2_reg;
    logic [32:0] usq2_reg;
    logic [48:0] ucb2_reg;
    logic [49:0] ucb_full;
    coord_t      pt2_reg [4][3];
    // stage 3: weights
    logic        v3_reg;
    logic [1:0]  st3_reg;
    coord_t      w3_reg [4];
    coord_t      pt3_reg [4][3];
    // stage 4: products
    logic               v4_reg;
    logic [1:0]         st4_reg;
    logic signed [63:0] prod4_reg [3][4];
    // stage 5: pair sums
    logic               v5_reg;
    logic [1:0]         st5_reg;
    logic signed [64:0] pair5_reg [3][2];
    // output register
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    coord_t      m_out_reg [3];

    // weight datapath
    logic signed [52:0] up, u2p, u3p;
    logic signed [52:0] pw [4];
    logic signed [36:0] ut, u2t;
    logic signed [36:0] tw [4];
    logic signed [21:0] ua;
    logic signed [21:0] aw [4];
    coord_t             w_sel [4];

    // final sum
    logic signed [65:0] tot [3];
    logic signed [37:0] q_val [3];
    coord_t             sat_val [3];

    // whole pipeline moves whenever the output register can take a beat
    assign adv      = !m_valid_reg || m_tready;
    assign in_ready = adv;
    assign pop      = in_valid && adv;
    assign ram_we   = pop && (in_item.status == ST_WRITTEN);
    assign ram_re   = pop && (in_item.status == ST_EVAL);
    assign usq_full = 34'(in_item.u) * 34'(in_item.u);
    assign ucb_full = 50'(usq1_reg) * 50'(u1_reg);

    // four copies of the store so the four neighbors are read in parallel
    for (genvar k = 0; k < 4; k++) begin : g_store
        assign rd_slot[k] = in_slot + SW'(k);
        assign rd_addr[k] = rd_slot[k][AW-1:0];

        crse_ram #(
            .WIDTH (96),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (in_slot[AW-1:0]),
            .wdata ({in_item.z, in_item.y, in_item.x}),
            .re    (ram_re),
            .raddr (rd_addr[k]),
            .rdata (rd_data[k])
        );
    end

    // basis weights in Q.28, 0.5 factor folded into the shifts
    always_comb begin
        up  = {36'd0, u2_reg};
        u2p = {20'd0, usq2_reg};
        u3p = {4'd0, ucb2_reg};
        pw[0] = (u2p <<< 17) - u3p - (up <<< 32);
        pw[1] = (u3p <<< 1) + u3p - (u2p <<< 18) - (u2p <<< 16) + (53'sd1 <<< 49);
        pw[2] = (u2p <<< 18) + (up <<< 32) - (u3p <<< 1) - u3p;
        pw[3] = u3p - (u2p <<< 16);

        ut  = {20'd0, u2_reg};
        u2t = {4'd0, usq2_reg};
        tw[0] = (ut <<< 18) - (u2t <<< 1) - u2t - (37'sd1 <<< 32);
        tw[1] = (u2t <<< 3) + u2t - (ut <<< 19) - (ut <<< 17);
        tw[2] = (ut <<< 19) + (37'sd1 <<< 32) - (u2t <<< 3) - u2t;
        tw[3] = (u2t <<< 1) + u2t - (ut <<< 17);

        ua = {5'd0, u2_reg};
        aw[0] = (22'sd1 <<< 18) - (ua <<< 2) - (ua <<< 1);
        aw[1] = (ua <<< 4) + (ua <<< 1) - 22'sd655360;
        aw[2] = (22'sd1 <<< 19) - (ua <<< 4) - (ua <<< 1);
        aw[3] = (ua <<< 2) + (ua <<< 1) - (22'sd1 <<< 17);

        for (int k = 0; k < 4; k++) begin
            pw[k] = pw[k] + (53'sd1 <<< 20);
            tw[k] = tw[k] + 37'sd16;
            case (mode2_reg)
                MODE_POS: w_sel[k] = pw[k][52:21];
                MODE_TAN: w_sel[k] = tw[k][36:5];
                MODE_ACC: w_sel[k] = {aw[k][20:0], 11'd0};
                default:  w_sel[k] = '0;
            endcase
        end
    end

    // round to Q16.16 and saturate
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            tot[a]   = 66'(pair5_reg[a][0]) + 66'(pair5_reg[a][1]) + 66'sd134217728;
            q_val[a] = tot[a][65:28];
            if (q_val[a] > 38'sd2147483647) begin
                sat_val[a] = 32'sh7fffffff;
            end else if (q_val[a] < -38'sd2147483648) begin
                sat_val[a] = 32'sh80000000;
            end else begin
                sat_val[a] = q_val[a][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= pop;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg   <= in_item.status;
            mode1_reg <= in_item.mode;
            u1_reg    <= in_item.u;
            usq1_reg  <= usq_full[32:0];

            st2_reg   <= st1_reg;
            mode2_reg <= mode1_reg;
            u2_reg    <= u1_reg;
            usq2_reg  <= usq1_reg;
            ucb2_reg  <= ucb_full[48:0];
            for (int k = 0; k < 4; k++) begin
                pt2_reg[k][0] <= rd_data[k][31:0];
                pt2_reg[k][1] <= rd_data[k][63:32];
                pt2_reg[k][2] <= rd_data[k][95:64];
            end

            st3_reg <= st2_reg;
            for (int k = 0; k < 4; k++) begin
                w3_reg[k] <= w_sel[k];
                for (int a = 0; a < 3; a++) begin
                    pt3_reg[k][a] <= pt2_reg[k][a];
                end
            end

            st4_reg <= st3_reg;
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 4; k++) begin
                    prod4_reg[a][k] <= pt3_reg[k][a] * w3_reg[k];
                end
            end

            st5_reg <= st4_reg;
            for (int a = 0; a < 3; a++) begin
                pair5_reg[a][0] <= 65'(prod4_reg[a][0]) + 65'(prod4_reg[a][1]);
                pair5_reg[a][1] <= 65'(prod4_reg[a][2]) + 65'(prod4_reg[a][3]);
            end

            m_status_reg <= st5_reg;
            for (int a = 0; a < 3; a++) begin
                m_out_reg[a] <= (st5_reg == ST_EVAL) ? sat_val[a] : '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_out_reg[2], m_out_reg[1], m_out_reg[0]};
    assign m_tuser  = m_status_reg;

    // a popped beat is either a store write or a store read, never both
    assert property (@(posedge aclk) disable iff (!aresetn) !(ram_we && ram_re))
        else $error("store written and read by the same beat");

    // a stalled output freezes every stage behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}))
        else $error("back pipeline moved while output stalled");

    // results that are not evaluations carry zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != ST_EVAL) |-> (m_tdata == '0))
        else $error("non-evaluation result with nonzero data");

endmodule

`default_nettype wire

/* hdl/catmull_rom_spline_evaluator.sv */
// Uniform Catmull-Rom spline evaluator, top level.
//
// Input beats on s_t*: tuser selects a point write or a position, tangent or
// acceleration evaluation at global t. Each input beat yields exactly one
// result beat on m_t*, in order: three Q16.16 coordinates plus a status.
// cfg_wr_en/cfg_wr_data set the number of control points in use; write it
// only while no beat is in flight.
// Throughput: one beat per cycle in and out while m_tready is high. Each
// beat passes through the front queue, then a five-stage back pipeline:
// store read and u^2, u^3, weights, products, pair sums, then the output
// register.
// The front queue holds 4 beats; when m_tready is low while a result waits,
// the back pipeline freezes and the queue fills, after which s_tready drops.
// Reset clears the point count to zero and empties the queue and pipeline.
// The point store is not cleared: evaluating over a slot that was never
// written returns unspecified coordinates.
`default_nettype none

module catmull_rom_spline_evaluator #(
    parameter int MAX_POINTS  = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,   // point_count
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
    // param_t[118:102], zero pad[119]
    input  logic [119:0] s_tdata,
    input  logic [1:0]   s_tuser,       // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_tdata,
    output logic [1:0]   m_tuser        // status[1:0]
);

    import crse_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = (AW > 7) ? AW : 7;
    localparam int QW = $bits(crse_item_t) + SW;

    crse_item_t    f_item, b_item;
    logic [SW-1:0] f_slot, b_slot;
    logic          q_valid, q_ready;

    crse_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mode        (s_tuser),
        .point_index (s_tdata[5:0]),
        .coord_x     (s_tdata[37:6]),
        .coord_y     (s_tdata[69:38]),
        .coord_z     (s_tdata[101:70]),
        .param_t     (s_tdata[118:102]),
        .item        (f_item),
        .slot        (f_slot)
    );

    crse_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   ({f_slot, f_item}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  ({b_slot, b_item})
    );

    crse_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (b_item),
        .in_slot  (b_slot),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* test/catmull_rom_spline_evaluator_tb.sv */
// Self-checking testbench for the Catmull-Rom spline evaluator: directed rows, then random traffic.
`timescale 1ns / 100ps

module catmull_rom_spline_evaluator_tb;
    import crse_pkg::*;

    localparam int     N_POINTS  = 64;
    localparam longint ONE_Q16   = 65536;
    localparam int     N_DIR     = 29;
    localparam int     BEAT_GOAL = 650;

    localparam bit ROW_CFG   = 1'b1;
    localparam bit ROW_BEAT  = 1'b0;
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  idx;
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic [16:0] t;
    } point_beat_t;

    typedef struct packed {
        coord_t [2:0] xyz;      // [0] = x
        logic [1:0]   status;
    } spline_out_t;

    typedef struct packed {
        bit          kind;
        logic [6:0]  count;
        logic [1:0]  mode;
        logic [5:0]  idx;
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic [16:0] t;
        bit          check;
        coord_t      ex;
        coord_t      ey;
        coord_t      ez;
        logic [1:0]  est;
    } dir_row_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [6:0]   cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata     = '0;
    logic [1:0]   s_tuser     = MODE_WRITE;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    // Predictor state
    logic [6:0]        model_count = '0;
    coord_t            pts [N_POINTS][3];
    logic [N_POINTS-1:0] slot_loaded = '0;

    spline_out_t pending_results [$];
    int          failures      = 0;
    int          beats_counted = 0;
    bit          calm          = 1'b0;
    int          ready_hold    = 0;
    string       axis_name [3] = '{"out_x", "out_y", "out_z"};

    // Directed rows. Typed expectations only where the answer is obvious:
    // status codes, and position at u = 0 or u = 1 equal to a control point.
    dir_row_t dir_rows [N_DIR] = '{
        // count 0 after reset: too few points, write index out of range
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          TYPED, 32'h0, 32'h0, 32'h0, ST_FEW},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_IGNORED},
        '{ROW_CFG, 7'd3, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_WRITTEN},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd3, 32'h0003_0000, 32'h0, 32'hFFFF_8000,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_IGNORED},
        '{ROW_BEAT, 7'd0, MODE_TAN, 6'd0, 32'h0, 32'h0, 32'h0, 17'd65536,
          TYPED, 32'h0, 32'h0, 32'h0, ST_FEW},
        // count above the maximum acts as 64
        '{ROW_CFG, 7'd127, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_WRITTEN},
        // four points: one segment
        '{ROW_CFG, 7'd4, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_WRITTEN},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd1, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_WRITTEN},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_WRITTEN},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd3, 32'h0003_0000, 32'h0, 32'hFFFF_8000,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_WRITTEN},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd4, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_0003,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_IGNORED},
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          TYPED, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'd65536,
          TYPED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, ST_EVAL},
        // t above one clamps
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'h1FFFF,
          TYPED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_TAN, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_TAN, 6'd0, 32'h0, 32'h0, 32'h0, 17'd32768,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_ACC, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_ACC, 6'd0, 32'h0, 32'h0, 32'h0, 17'd65536,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_ACC, 6'd0, 32'h0, 32'h0, 32'h0, 17'd12345,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'h0AAAA,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        // five points: two segments, boundary at t = 0.5
        '{ROW_CFG, 7'd5, MODE_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 17'd0,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_WRITE, 6'd4, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_0003,
          17'd0, TYPED, 32'h0, 32'h0, 32'h0, ST_WRITTEN},
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'd32768,
          TYPED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'd32769,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_POS, 6'd0, 32'h0, 32'h0, 32'h0, 17'd65536,
          TYPED, 32'h0003_0000, 32'h0, 32'hFFFF_8000, ST_EVAL},
        '{ROW_BEAT, 7'd0, MODE_TAN, 6'd0, 32'h0, 32'h0, 32'h0, 17'd65535,
          PREDICTED, 32'h0, 32'h0, 32'h0, ST_EVAL}
    };

    logic [6:0] count_plan [11] = '{7'd4, 7'd64, 7'd0, 7'd127, 7'd3, 7'd5, 7'd1, 7'd2,
                                    7'd100, 7'd65, 7'd7};

    catmull_rom_spline_evaluator #(
        .MAX_POINTS(N_POINTS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int points_in_use();
        return (model_count > 7'd64) ? N_POINTS : int'(model_count);
    endfunction

    function automatic longint round_half_up(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic coord_t sat_q16(longint acc);
        longint v;
        v = round_half_up(acc, 28);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // One step of the curve: stores a point or evaluates at global t.
    function automatic spline_out_t spline_result(point_beat_t b);
        spline_out_t r;
        int          n, a, k;
        longint      tq, s, p, u, u2, u3, acc;
        longint      w [4];
        r = '0;
        n = points_in_use();
        if (b.mode == MODE_WRITE) begin
            if (b.idx < n) begin
                pts[b.idx][0] = b.x;
                pts[b.idx][1] = b.y;
                pts[b.idx][2] = b.z;
                slot_loaded[b.idx] = 1'b1;
                r.status = ST_WRITTEN;
            end else begin
                r.status = ST_IGNORED;
            end
            return r;
        end
        if (n < 4) begin
            r.status = ST_FEW;
            return r;
        end
        tq = (b.t > 17'd65536) ? ONE_Q16 : longint'(b.t);
        s  = (n - 3) * tq;
        p  = (s + ONE_Q16 - 1) >>> 16;
        if (p == 0)
            p = 1;
        u  = s - (p - 1) * ONE_Q16;
        u2 = u * u;
        u3 = u2 * u;
        // weights carry the 0.5 factor, Q.28
        case (b.mode)
            MODE_POS: begin
                w[0] = round_half_up(-u3 + 2 * u2 * ONE_Q16 - u * ONE_Q16 * ONE_Q16, 21);
                w[1] = round_half_up(3 * u3 - 5 * u2 * ONE_Q16
                                     + 2 * ONE_Q16 * ONE_Q16 * ONE_Q16, 21);
                w[2] = round_half_up(-3 * u3 + 4 * u2 * ONE_Q16 + u * ONE_Q16 * ONE_Q16, 21);
                w[3] = round_half_up(u3 - u2 * ONE_Q16, 21);
            end
            MODE_TAN: begin
                w[0] = round_half_up(-3 * u2 + 4 * u * ONE_Q16 - ONE_Q16 * ONE_Q16, 5);
                w[1] = round_half_up(9 * u2 - 10 * u * ONE_Q16, 5);
                w[2] = round_half_up(-9 * u2 + 8 * u * ONE_Q16 + ONE_Q16 * ONE_Q16, 5);
                w[3] = round_half_up(3 * u2 - 2 * u * ONE_Q16, 5);
            end
            default: begin
                w[0] = (-6 * u + 4 * ONE_Q16) * 2048;
                w[1] = (18 * u - 10 * ONE_Q16) * 2048;
                w[2] = (-18 * u + 8 * ONE_Q16) * 2048;
                w[3] = (6 * u - 2 * ONE_Q16) * 2048;
            end
        endcase
        // full sum fits in 64 bits
        for (a = 0; a < 3; a++) begin
            acc = 0;
            for (k = 0; k < 4; k++)
                acc += longint'(pts[p - 1 + k][a]) * w[k];
            r.xyz[a] = sat_q16(acc);
        end
        r.status = ST_EVAL;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 82)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_t(int n);
        int r, k, v;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 17'($urandom_range(0, 65536));
        if (r == 6 && n >= 4) begin
            // around a segment boundary
            k = $urandom_range(0, n - 3);
            v = (k * 65536) / (n - 3) + $urandom_range(0, 2) - 1;
            return 17'((v < 0) ? 0 : v);
        end
        if (r <= 7)
            return ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
        return 17'($urandom_range(65537, 131071));
    endfunction

    function automatic point_beat_t random_beat(int n);
        point_beat_t b;
        int          r;
        b.mode = MODE_WRITE;
        b.idx  = 6'($urandom_range(0, 63));
        b.x    = pick_coord();
        b.y    = pick_coord();
        b.z    = pick_coord();
        b.t    = 17'($urandom_range(0, 131071));
        r = $urandom_range(0, 99);
        if (r < 65) begin
            b.mode = 2'($urandom_range(1, 3));
            b.t    = pick_t(n);
        end else if (r < 85) begin
            if (n > 0)
                b.idx = 6'($urandom_range(0, n - 1));
        end else begin
            b.mode = 2'($urandom_range(0, 3));
        end
        return b;
    endfunction

    task automatic send_beat(point_beat_t b, bit typed, spline_out_t want);
        int          gap;
        spline_out_t got;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.mode;
        s_tdata  <= {1'b0, b.t, b.z, b.y, b.x, b.idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        got = spline_result(b);
        pending_results.insert(pending_results.size(), typed ? want : got);
        if (got.status != ST_IGNORED)
            beats_counted++;
    endtask

    // Count register is only written with the pipe empty.
    task automatic set_point_count(logic [6:0] v);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_count = v;
    endtask

    task automatic note_mismatch(string field, longint want, longint got);
        failures++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // Output side backpressure: alternating ready runs and stalls.
    always @(posedge aclk) begin
        if (calm) begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= !m_tready;
            ready_hold <= m_tready ? pick_gap() : $urandom_range(0, 12);
        end
    end

    always @(posedge aclk) begin : result_check
        spline_out_t want;
        int          a;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected beat, status", -1, m_tuser);
            end else begin
                want = pending_results.pop_front();
                for (a = 0; a < 3; a++)
                    if ($signed(m_tdata[32 * a +: 32]) !== want.xyz[a])
                        note_mismatch(axis_name[a], want.xyz[a], $signed(m_tdata[32 * a +: 32]));
                if (m_tuser !== want.status)
                    note_mismatch("status", want.status, m_tuser);
            end
        end
    end

    initial begin : stimulus
        point_beat_t b;
        spline_out_t want;
        int          i, phase, n_use, len;
        logic [6:0]  count;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                set_point_count(dir_rows[i].count);
            end else begin
                b.mode      = dir_rows[i].mode;
                b.idx       = dir_rows[i].idx;
                b.x         = dir_rows[i].x;
                b.y         = dir_rows[i].y;
                b.z         = dir_rows[i].z;
                b.t         = dir_rows[i].t;
                want.xyz    = {dir_rows[i].ez, dir_rows[i].ey, dir_rows[i].ex};
                want.status = dir_rows[i].est;
                send_beat(b, dir_rows[i].check, want);
            end
        end

        phase = 0;
        while (beats_counted < BEAT_GOAL) begin
            if (phase < 11)
                count = count_plan[phase];
            else if ($urandom_range(0, 9) < 5)
                count = 7'($urandom_range(4, 16));
            else if ($urandom_range(0, 1) != 0)
                count = 7'($urandom_range(17, 64));
            else
                count = 7'($urandom_range(0, 127));
            calm = ($urandom_range(0, 3) == 0);
            set_point_count(count);
            n_use = points_in_use();
            // every slot in use gets a point before any evaluation reads it
            for (i = 0; i < n_use; i++) begin
                if (!slot_loaded[i]) begin
                    b      = random_beat(n_use);
                    b.mode = MODE_WRITE;
                    b.idx  = 6'(i);
                    send_beat(b, PREDICTED, '0);
                end
            end
            len = $urandom_range(30, 70);
            for (i = 0; i < len; i++)
                send_beat(random_beat(n_use), PREDICTED, '0);
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (failures == 0)
            $display("catmull_rom_spline_evaluator_tb: done, clean");
        else
            $display("catmull_rom_spline_evaluator_tb: done, errors");
        $finish;
    end

    initial begin
        #7_000_000;
        $display("catmull_rom_spline_evaluator_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
hdl/crse_pkg.sv
hdl/crse_ram.sv
hdl/crse_fifo.sv
hdl/crse_front.sv
hdl/crse_back.sv
hdl/catmull_rom_spline_evaluator.sv
test/catmull_rom_spline_evaluator_tb.sv
